@@ rtl/core/ray_sphere_closest_hit_unit_macros.svh @@
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_unit_macros.svh
// Assertion macros for the ray/sphere closest-hit unit checkers.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSCH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsch assertion failed");

// next-cycle implication, disabled during reset
`define RSCH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsch assertion failed");

`endif

@@ rtl/core/rsch_pkg.sv @@
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared constants, operation codes and interface types of the closest-hit unit.
// ----------------------------------------------------------------------------
package rsch_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ID_BITS   = 16;

    localparam int W_CRD  = 32;
    localparam int W_DIR  = 18;
    localparam int W_RAD  = 31;
    localparam int W_IDX  = 3;
    localparam int W_TV   = W_CRD + 1;
    localparam int W_MOP  = W_TV;
    localparam int W_PROD = 2 * W_MOP;
    localparam int W_DOT  = 53;
    localparam int W_V    = W_DOT - FRAC_BITS;
    localparam int W_U    = 36;
    localparam int W_UH   = W_U / 2;
    localparam int W_CC   = 50;
    localparam int W_RR   = 46;
    localparam int W_VSQ  = 2 * W_U;
    localparam int W_VV   = W_VSQ - FRAC_BITS;
    localparam int W_DISC = 58;
    localparam int W_SQIN = 64;
    localparam int W_ROOT = W_SQIN / 2;
    localparam int SQ_STEPS = W_SQIN / 2;
    localparam int W_CNT  = $clog2(SQ_STEPS);
    localparam int W_T    = 38;

    localparam logic signed [W_CRD-1:0] NO_HIT = 32'sh7FFF_FFFF;
    localparam logic [W_DIR-1:0] DIR_Z_RESET   = 18'h1_0000;

    // configuration register indexes
    localparam logic [W_IDX-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [W_IDX-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [W_IDX-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [W_IDX-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [W_IDX-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [W_IDX-1:0] CFG_DIR_Z    = 3'd5;

    // multiplier operand selects
    localparam logic [3:0] MUL_NONE  = 4'd0;
    localparam logic [3:0] MUL_TD0   = 4'd1;
    localparam logic [3:0] MUL_TD1   = 4'd2;
    localparam logic [3:0] MUL_TD2   = 4'd3;
    localparam logic [3:0] MUL_TV0SQ = 4'd4;
    localparam logic [3:0] MUL_TV1SQ = 4'd5;
    localparam logic [3:0] MUL_TV2SQ = 4'd6;
    localparam logic [3:0] MUL_RSQ   = 4'd7;
    localparam logic [3:0] MUL_ULL   = 4'd8;
    localparam logic [3:0] MUL_UHL   = 4'd9;
    localparam logic [3:0] MUL_UHH   = 4'd10;
    localparam logic [3:0] MUL_TP0   = 4'd11;
    localparam logic [3:0] MUL_TP1   = 4'd12;
    localparam logic [3:0] MUL_TP2   = 4'd13;

    // product accumulate selects
    localparam logic [3:0] ACC_NONE    = 4'd0;
    localparam logic [3:0] ACC_DOT_LD  = 4'd1;
    localparam logic [3:0] ACC_DOT_ADD = 4'd2;
    localparam logic [3:0] ACC_CC_LD   = 4'd3;
    localparam logic [3:0] ACC_CC_ADD  = 4'd4;
    localparam logic [3:0] ACC_RR_LD   = 4'd5;
    localparam logic [3:0] ACC_VV_LD   = 4'd6;
    localparam logic [3:0] ACC_VV_MID  = 4'd7;
    localparam logic [3:0] ACC_VV_HI   = 4'd8;
    localparam logic [3:0] ACC_PT0     = 4'd9;
    localparam logic [3:0] ACC_PT1     = 4'd10;
    localparam logic [3:0] ACC_PT2     = 4'd11;

    typedef struct packed {
        logic [2:0][W_CRD-1:0] org;
        logic [2:0][W_DIR-1:0] dir;
    } cfg_t;

    typedef struct packed {
        logic             accept;
        logic [3:0]       mul_op;
        logic [3:0]       acc_op;
        logic             disc_ld;
        logic             sq_step;
        logic [W_CNT-1:0] sq_idx;
        logic             t_ld;
        logic             out_ld;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic upd;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/core/rsch_cfg.sv @@
// ----------------------------------------------------------------------------
// rsch_cfg
// Ray origin and direction registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module rsch_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsch_pkg::W_IDX-1:0]    cfg_index,
    input  logic [rsch_pkg::W_CRD-1:0]    cfg_data,
    output rsch_pkg::cfg_t                cfg
);
    import rsch_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: cfg_next.org[0] = cfg_data;
                CFG_ORIGIN_Y: cfg_next.org[1] = cfg_data;
                CFG_ORIGIN_Z: cfg_next.org[2] = cfg_data;
                CFG_DIR_X:    cfg_next.dir[0] = cfg_data[W_DIR-1:0];
                CFG_DIR_Y:    cfg_next.dir[1] = cfg_data[W_DIR-1:0];
                CFG_DIR_Z:    cfg_next.dir[2] = cfg_data[W_DIR-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.org    <= '0;
            cfg_reg.dir[0] <= '0;
            cfg_reg.dir[1] <= '0;
            cfg_reg.dir[2] <= DIR_Z_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/rsch_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsch_ctrl
// Sequencer: multiply schedule, square root iterations, best update, output.
// ----------------------------------------------------------------------------
module rsch_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rsch_pkg::sts_t  sts,
    output rsch_pkg::cmd_t  cmd
);
    import rsch_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DISC  = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_TVAL  = 3'd4;
    localparam logic [2:0] ST_POINT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [W_CNT-1:0] MUL_LAST = W_CNT'(10);
    localparam logic [W_CNT-1:0] SQ_LAST  = W_CNT'(SQ_STEPS - 1);
    localparam logic [W_CNT-1:0] PT_LAST  = W_CNT'(3);

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [W_CNT-1:0] cnt_reg;
    logic [W_CNT-1:0] cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_op  = MUL_NONE;
        cmd.acc_op  = ACC_NONE;
        cmd.sq_idx  = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                // product of step n is accumulated in step n+1
                case (cnt_reg)
                    5'd0:    begin cmd.mul_op = MUL_TD0;   cmd.acc_op = ACC_NONE;    end
                    5'd1:    begin cmd.mul_op = MUL_TD1;   cmd.acc_op = ACC_DOT_LD;  end
                    5'd2:    begin cmd.mul_op = MUL_TD2;   cmd.acc_op = ACC_DOT_ADD; end
                    5'd3:    begin cmd.mul_op = MUL_TV0SQ; cmd.acc_op = ACC_DOT_ADD; end
                    5'd4:    begin cmd.mul_op = MUL_TV1SQ; cmd.acc_op = ACC_CC_LD;   end
                    5'd5:    begin cmd.mul_op = MUL_TV2SQ; cmd.acc_op = ACC_CC_ADD;  end
                    5'd6:    begin cmd.mul_op = MUL_RSQ;   cmd.acc_op = ACC_CC_ADD;  end
                    5'd7:    begin cmd.mul_op = MUL_ULL;   cmd.acc_op = ACC_RR_LD;   end
                    5'd8:    begin cmd.mul_op = MUL_UHL;   cmd.acc_op = ACC_VV_LD;   end
                    5'd9:    begin cmd.mul_op = MUL_UHH;   cmd.acc_op = ACC_VV_MID;  end
                    5'd10:   begin cmd.mul_op = MUL_NONE;  cmd.acc_op = ACC_VV_HI;   end
                    default: begin cmd.mul_op = MUL_NONE;  cmd.acc_op = ACC_NONE;    end
                endcase
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_DISC;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DISC:
            begin
                cmd.disc_ld = 1'b1;
                cnt_next    = '0;
                state_next  = sts.hit ? ST_SQRT : ST_TVAL;
            end
            ST_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = ST_TVAL;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TVAL:
            begin
                cmd.t_ld   = 1'b1;
                cnt_next   = '0;
                state_next = sts.upd ? ST_POINT : ST_DONE;
            end
            ST_POINT:
            begin
                case (cnt_reg)
                    5'd0:    begin cmd.mul_op = MUL_TP0;  cmd.acc_op = ACC_NONE; end
                    5'd1:    begin cmd.mul_op = MUL_TP1;  cmd.acc_op = ACC_PT0;  end
                    5'd2:    begin cmd.mul_op = MUL_TP2;  cmd.acc_op = ACC_PT1;  end
                    5'd3:    begin cmd.mul_op = MUL_NONE; cmd.acc_op = ACC_PT2;  end
                    default: begin cmd.mul_op = MUL_NONE; cmd.acc_op = ACC_NONE; end
                endcase
                if (cnt_reg == PT_LAST)
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/core/rsch_dp.sv @@
// ----------------------------------------------------------------------------
// rsch_dp
// Datapath: shared multiplier with accumulators, bit-serial square root,
// best-hit state and output register.
// ----------------------------------------------------------------------------
module rsch_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rsch_pkg::cfg_t                      cfg,
    input  rsch_pkg::cmd_t                      cmd,
    output rsch_pkg::sts_t                      sts,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_x,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_y,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_z,
    input  logic [rsch_pkg::W_RAD-1:0]          radius,
    input  logic [rsch_pkg::ID_BITS-1:0]        sphere_id,
    input  logic                                new_ray,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                updated,
    output logic signed [rsch_pkg::W_CRD-1:0]   t_value,
    output logic signed [rsch_pkg::W_CRD-1:0]   best_distance,
    output logic [rsch_pkg::ID_BITS-1:0]        best_id,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_x,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_y,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_z
);
    import rsch_pkg::*;

    localparam logic signed [W_T-1:0] SAT_HI = 38'sd2147483647;
    localparam logic signed [W_T-1:0] SAT_LO = -38'sd2147483648;
    localparam logic [W_SQIN-1:0]     SQ_TOP = 64'h4000_0000_0000_0000;

    function automatic logic signed [W_CRD-1:0] sat32(input logic signed [W_T-1:0] x);
        logic signed [W_CRD-1:0] y;
        if (x > SAT_HI)
            y = NO_HIT;
        else if (x < SAT_LO)
            y = SAT_LO[W_CRD-1:0];
        else
            y = x[W_CRD-1:0];
        return y;
    endfunction

    // item registers
    logic signed [W_TV-1:0]   tv0_reg, tv1_reg, tv2_reg;
    logic [W_RAD-1:0]         r_reg;
    logic [ID_BITS-1:0]       id_reg;

    // multiplier and accumulators
    logic signed [W_MOP-1:0]  ma, mb;
    logic signed [W_PROD-1:0] p_reg;
    logic signed [W_DOT-1:0]  dot_reg;
    logic [W_CC-1:0]          cc_reg;
    logic [W_RR-1:0]          rr_reg;
    logic [W_U-1:0]           u_reg;
    logic [W_VSQ-1:0]         vsq_reg;

    // square root
    logic                     hit_reg;
    logic [W_SQIN-1:0]        x_reg;
    logic [W_SQIN-1:0]        res_reg;

    // result and best hit
    logic signed [W_CRD-1:0]  t_reg;
    logic                     upd_reg;
    logic signed [W_CRD-1:0]  best_t_reg;
    logic [ID_BITS-1:0]       best_id_reg;
    logic signed [W_CRD-1:0]  bp0_reg, bp1_reg, bp2_reg;

    // output register
    logic                     out_valid_reg;
    logic                     hit_out_reg, upd_out_reg;
    logic signed [W_CRD-1:0]  t_out_reg, best_out_reg;
    logic [ID_BITS-1:0]       id_out_reg;
    logic signed [W_CRD-1:0]  px_out_reg, py_out_reg, pz_out_reg;

    logic signed [W_V-1:0]    v_w;
    logic signed [W_V-1:0]    v_abs;
    logic signed [W_DISC-1:0] disc_w;
    logic                     disc_pos;
    logic [W_SQIN-1:0]        rad_w;
    logic [W_SQIN-1:0]        sq_bit;
    logic [W_SQIN-1:0]        sq_sum;
    logic signed [W_T-1:0]    t_full;
    logic signed [W_CRD-1:0]  t_sat;
    logic                     upd_w;
    logic signed [W_CRD-1:0]  pt_org;
    logic signed [W_CRD-1:0]  pt_val;

    // --- multiplier operands ---
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_op)
            MUL_TD0:   begin ma = tv0_reg; mb = W_MOP'($signed(cfg.dir[0])); end
            MUL_TD1:   begin ma = tv1_reg; mb = W_MOP'($signed(cfg.dir[1])); end
            MUL_TD2:   begin ma = tv2_reg; mb = W_MOP'($signed(cfg.dir[2])); end
            MUL_TV0SQ: begin ma = tv0_reg; mb = tv0_reg; end
            MUL_TV1SQ: begin ma = tv1_reg; mb = tv1_reg; end
            MUL_TV2SQ: begin ma = tv2_reg; mb = tv2_reg; end
            MUL_RSQ:
            begin
                ma = $signed({2'b00, r_reg});
                mb = $signed({2'b00, r_reg});
            end
            MUL_ULL:
            begin
                ma = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_UH-1:0]});
                mb = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_UH-1:0]});
            end
            MUL_UHL:
            begin
                ma = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_U-1:W_UH]});
                mb = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_UH-1:0]});
            end
            MUL_UHH:
            begin
                ma = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_U-1:W_UH]});
                mb = $signed({{(W_MOP-W_UH){1'b0}}, u_reg[W_U-1:W_UH]});
            end
            MUL_TP0:   begin ma = W_MOP'(t_reg); mb = W_MOP'($signed(cfg.dir[0])); end
            MUL_TP1:   begin ma = W_MOP'(t_reg); mb = W_MOP'($signed(cfg.dir[1])); end
            MUL_TP2:   begin ma = W_MOP'(t_reg); mb = W_MOP'($signed(cfg.dir[2])); end
            default:   begin ma = '0; mb = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg <= ma * mb;
    end

    // --- derived values ---
    assign v_w   = dot_reg[W_DOT-1:FRAC_BITS];
    assign v_abs = v_w[W_V-1] ? -v_w : v_w;

    assign disc_w = $signed({{(W_DISC-W_VV){1'b0}}, vsq_reg[W_VSQ-1:FRAC_BITS]})
                  + $signed({{(W_DISC-W_RR){1'b0}}, rr_reg})
                  - $signed({{(W_DISC-W_CC){1'b0}}, cc_reg});
    assign disc_pos = !disc_w[W_DISC-1] && (|disc_w);
    assign rad_w    = (|disc_w[W_DISC-1:W_SQIN-FRAC_BITS]) ? '1
                    : {disc_w[W_SQIN-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

    assign sq_bit = SQ_TOP >> {cmd.sq_idx, 1'b0};
    assign sq_sum = res_reg + sq_bit;

    assign t_full = W_T'(v_w) - $signed({{(W_T-W_ROOT){1'b0}}, res_reg[W_ROOT-1:0]});
    assign t_sat  = sat32(t_full);
    assign upd_w  = hit_reg && (t_sat > 0) && (t_sat < best_t_reg);

    always_comb
    begin
        case (cmd.acc_op)
            ACC_PT0: pt_org = $signed(cfg.org[0]);
            ACC_PT1: pt_org = $signed(cfg.org[1]);
            ACC_PT2: pt_org = $signed(cfg.org[2]);
            default: pt_org = $signed(cfg.org[0]);
        endcase
    end
    assign pt_val = sat32(W_T'(pt_org)
                        + W_T'($signed(p_reg[W_CRD+W_DIR-1:FRAC_BITS])));

    assign sts.hit      = disc_pos;
    assign sts.upd      = upd_w;
    assign sts.out_free = !out_valid_reg || out_ready;

    // --- item load, accumulators, square root, t ---
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tv0_reg <= W_TV'(center_x) - W_TV'($signed(cfg.org[0]));
            tv1_reg <= W_TV'(center_y) - W_TV'($signed(cfg.org[1]));
            tv2_reg <= W_TV'(center_z) - W_TV'($signed(cfg.org[2]));
            r_reg   <= radius;
            id_reg  <= sphere_id;
        end

        case (cmd.acc_op)
            ACC_DOT_LD:  dot_reg <= p_reg[W_DOT-1:0];
            ACC_DOT_ADD: dot_reg <= dot_reg + p_reg[W_DOT-1:0];
            ACC_CC_LD:
            begin
                cc_reg <= p_reg[W_CC+FRAC_BITS-1:FRAC_BITS];
                u_reg  <= v_abs[W_U-1:0];
            end
            ACC_CC_ADD:  cc_reg <= cc_reg + p_reg[W_CC+FRAC_BITS-1:FRAC_BITS];
            ACC_RR_LD:   rr_reg <= p_reg[W_RR+FRAC_BITS-1:FRAC_BITS];
            ACC_VV_LD:   vsq_reg <= {{(W_VSQ-2*W_UH){1'b0}}, p_reg[2*W_UH-1:0]};
            ACC_VV_MID:
                vsq_reg <= vsq_reg
                         + {{(W_VSQ-3*W_UH-1){1'b0}}, p_reg[2*W_UH-1:0], {(W_UH+1){1'b0}}};
            ACC_VV_HI:
                vsq_reg <= vsq_reg + {p_reg[2*W_UH-1:0], {(2*W_UH){1'b0}}};
            default: ;
        endcase

        if (cmd.disc_ld)
        begin
            hit_reg <= disc_pos;
            x_reg   <= rad_w;
            res_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            if (x_reg >= sq_sum)
            begin
                x_reg   <= x_reg - sq_sum;
                res_reg <= (res_reg >> 1) + sq_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end

        if (cmd.t_ld)
        begin
            t_reg   <= hit_reg ? t_sat : '0;
            upd_reg <= upd_w;
        end
    end

    // --- best hit state ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_t_reg  <= NO_HIT;
            best_id_reg <= '0;
            bp0_reg     <= '0;
            bp1_reg     <= '0;
            bp2_reg     <= '0;
        end
        else if (cmd.accept && new_ray)
        begin
            best_t_reg  <= NO_HIT;
            best_id_reg <= '0;
            bp0_reg     <= '0;
            bp1_reg     <= '0;
            bp2_reg     <= '0;
        end
        else
        begin
            if (cmd.t_ld && upd_w)
            begin
                best_t_reg  <= t_sat;
                best_id_reg <= id_reg;
            end
            if (upd_reg && (cmd.acc_op == ACC_PT0))
                bp0_reg <= pt_val;
            if (upd_reg && (cmd.acc_op == ACC_PT1))
                bp1_reg <= pt_val;
            if (upd_reg && (cmd.acc_op == ACC_PT2))
                bp2_reg <= pt_val;
        end
    end

    // --- output register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_ld)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            hit_out_reg  <= hit_reg;
            upd_out_reg  <= upd_reg;
            t_out_reg    <= t_reg;
            best_out_reg <= best_t_reg;
            id_out_reg   <= best_id_reg;
            px_out_reg   <= bp0_reg;
            py_out_reg   <= bp1_reg;
            pz_out_reg   <= bp2_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_out_reg;
    assign updated       = upd_out_reg;
    assign t_value       = t_out_reg;
    assign best_distance = best_out_reg;
    assign best_id       = id_out_reg;
    assign point_x       = px_out_reg;
    assign point_y       = py_out_reg;
    assign point_z       = pz_out_reg;

endmodule

@@ rtl/core/ray_sphere_closest_hit_unit.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit_unit
// Closest-hit search of one configured ray against a stream of spheres.
// ----------------------------------------------------------------------------
// One sphere is processed at a time. After acceptance the unit uses the
// shared 33x33 multiplier (dot product, squared lengths, radius and v
// squared), forms the discriminant, runs the bit-serial square root when
// the ray hits, computes t with the best-hit compare, uses the multiplier
// again for the hit point when the sphere becomes the closest, and loads
// the output register once that register is free. Only then is the next
// sphere taken, so a new sphere is not accepted before the last is done.
// On a hit the square root iterations take most of the time per sphere.
// A finished result waits in the output register while the next sphere
// is already in work.
// Configuration writes are always ready and must only happen while idle.
module ray_sphere_closest_hit_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsch_pkg::W_IDX-1:0]          cfg_index,
    input  logic [rsch_pkg::W_CRD-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_x,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_y,
    input  logic signed [rsch_pkg::W_CRD-1:0]   center_z,
    input  logic [rsch_pkg::W_RAD-1:0]          radius,
    input  logic [rsch_pkg::ID_BITS-1:0]        sphere_id,
    input  logic                                new_ray,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                updated,
    output logic signed [rsch_pkg::W_CRD-1:0]   t_value,
    output logic signed [rsch_pkg::W_CRD-1:0]   best_distance,
    output logic [rsch_pkg::ID_BITS-1:0]        best_id,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_x,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_y,
    output logic signed [rsch_pkg::W_CRD-1:0]   point_z
);
    import rsch_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    rsch_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rsch_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius        (radius),
        .sphere_id     (sphere_id),
        .new_ray       (new_ray),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .updated       (updated),
        .t_value       (t_value),
        .best_distance (best_distance),
        .best_id       (best_id),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z)
    );

endmodule

@@ rtl/core/rsch_chk.sv @@
// ----------------------------------------------------------------------------
// rsch_chk
// Port-level checker for the closest-hit unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_sphere_closest_hit_unit_macros.svh"

module rsch_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                hit,
    input logic                                updated,
    input logic signed [rsch_pkg::W_CRD-1:0]   t_value,
    input logic signed [rsch_pkg::W_CRD-1:0]   best_distance
);
    import rsch_pkg::*;

    // a stalled transaction keeps its result
    `RSCH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(t_value) && $stable(best_distance))

    // only a hit can become the closest
    `RSCH_ASSERT_IMP(a_upd_hit, out_valid && updated, hit)

    // a new closest hit is positive and becomes the best distance
    `RSCH_ASSERT_IMP(a_upd_best, out_valid && updated, (t_value > 0) && (best_distance == t_value))

    // a miss reports zero distance
    `RSCH_ASSERT_IMP(a_miss_zero, out_valid && !hit, t_value == '0)

endmodule

bind ray_sphere_closest_hit_unit rsch_chk u_rsch_chk (.*);
